@@ hw/rtl/erhp_pkg.sv @@
// shared types, constants and helpers of the echo ranging haptic pacer
// no dependencies; used by erhp_div and the top level
package erhp_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    // divider status toward the sequencer
    typedef struct packed
    {
        logic done;
        logic exact;
    } div_stat_t;

    localparam int FRAC_BITS     = 8;
    localparam int SCALE_BITS    = 16;
    localparam int STAMP_BITS    = 32;
    localparam int NEAR_BITS     = 8;
    localparam int FAR_BITS      = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int COUNT_BITS    = 32;
    localparam int OUT_BITS      = 56;
    localparam int NUM_RES       = 9;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CYCLES_PER_CM = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAR_LIMIT     = 2'd2;

    localparam logic [SCALE_BITS-1:0] CPC_RESET  = 16'd9280;
    localparam logic [NEAR_BITS-1:0]  NEAR_RESET = 8'd20;
    localparam logic [FAR_BITS-1:0]   FAR_RESET  = 10'd150;

    localparam logic [3:0] PERIOD_NONE = 4'd0;
    localparam logic [3:0] PERIOD_NEAR = 4'd1;
    localparam logic [3:0] PERIOD_MIN  = 4'd2;
    localparam logic [3:0] PERIOD_MAX  = 4'd10;
    // whole centimetres at which the period leaves its clamps
    localparam logic [FAR_BITS-1:0] PERIOD_LO_CM = 10'd20;
    localparam logic [FAR_BITS-1:0] PERIOD_HI_CM = 10'd100;

    typedef struct packed
    {
        logic [1:0]  pad;
        logic        buzz;
        logic [3:0]  pace_period;
        logic        in_range;
        logic [15:0] distance_q8;
        logic [31:0] pulse_cycles;
    } result_t;

    // floor(w / 10) for w below 128, by reciprocal multiply
    function automatic logic [3:0] div10(input logic [6:0] w);
        logic [14:0] p;
        p = 15'(w) * 15'd205;
        return p[14:11];
    endfunction

endpackage

@@ hw/rtl/erhp_div.sv @@
// bit-serial restoring divider: (dividend * 256) / divisor, one quotient bit per cycle
// depends on erhp_pkg
module erhp_div #(
    parameter int TIME_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [TIME_BITS-1:0]             dividend,
    input  logic [erhp_pkg::SCALE_BITS-1:0]  divisor,
    output logic [TIME_BITS+7:0]             quotient,
    output erhp_pkg::div_stat_t              stat
);
    import erhp_pkg::*;

    localparam int DW = TIME_BITS + FRAC_BITS;
    localparam int CW = $clog2(DW);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  exact_reg, exact_next;
    logic [CW-1:0]         cnt_reg;
    logic [DW-1:0]         dq_reg, dq_next;
    logic [SCALE_BITS-1:0] rem_reg, rem_next;
    logic [SCALE_BITS-1:0] div_reg;
    logic [SCALE_BITS:0]   shifted;
    logic [SCALE_BITS+1:0] diff;
    logic                  ge;

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_comb
    begin
        shifted  = {rem_reg, dq_reg[DW-1]};
        diff     = {1'b0, shifted} - {2'b00, div_reg};
        ge       = !diff[SCALE_BITS+1];
        rem_next = ge ? diff[SCALE_BITS-1:0] : shifted[SCALE_BITS-1:0];
        dq_next  = {dq_reg[DW-2:0], ge};
        // remainder of the whole part, seen once all time bits are in
        exact_next = (cnt_reg == CW'(TIME_BITS - 1)) ? (rem_next == '0) : exact_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            exact_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                exact_reg <= exact_next;
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= {dividend, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient   = dq_reg;
    assign stat.done  = done_reg;
    assign stat.exact = exact_reg;

endmodule

@@ hw/rtl/echo_ranging_haptic_pacer_unit.sv @@
// echo ranging haptic pacer, top level: edge stream in, range and buzz results out
// depends on erhp_pkg and erhp_div
//
// Each input item is an echo-pin edge (s_tuser 1 rising, 0 falling) with its cycle stamp.
// A rising edge stores the stamp, leaves the block idle and gives nothing. A falling edge gives
// one result: the pulse width, the distance in Q8 cm saturated at 65535, the in-range flag,
// the pace period and the buzz request. A falling edge keeps s_tready low from the moment
// it is taken until its result is loaded: the start of the bit-serial divider, its
// TIME_BITS + 8 quotient bits at one quotient bit per cycle, the sequencer seeing the
// divider finish, and the load of the output register. The finished result sits in that
// register, so the next edge is taken while it waits; a later result that finds it still
// full holds the block until m_tready frees it. Echo counter residues for periods
// 2 to 10 are kept alongside the counter, so the buzz decision needs no division.
// Configuration must be written through cfg_* only while the block is idle; the block
// itself has no check for this. cycles_per_cm of zero behaves as one.
module echo_ranging_haptic_pacer_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,   // stamp[31:0]
    input  logic                                 s_tuser,   // cmd
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pulse_cycles[31:0], distance_q8[47:32], in_range[48], pace_period[52:49],
    // buzz[53], zero[55:54]
    output logic [erhp_pkg::OUT_BITS-1:0]        m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [erhp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [erhp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import erhp_pkg::*;

    localparam int DW = TIME_BITS + FRAC_BITS;

    state_t                state_reg, state_next;
    logic [SCALE_BITS-1:0] cpc_reg;
    logic [NEAR_BITS-1:0]  near_reg;
    logic [FAR_BITS-1:0]   far_reg;
    logic [TIME_BITS-1:0]  rise_reg;
    logic [TIME_BITS-1:0]  pulse_reg;
    logic [COUNT_BITS-1:0] echo_counter_reg;
    logic [3:0]            res_reg [0:NUM_RES-1];
    logic                  m_tvalid_reg;
    result_t               out_reg;

    logic                  in_accept;
    logic                  div_start;
    logic                  load_out;
    logic [TIME_BITS-1:0]  stamp_t;
    logic [SCALE_BITS-1:0] scale;
    logic [DW-1:0]         quotient;
    div_stat_t             div_stat;
    logic [TIME_BITS-1:0]  whole;
    logic                  whole_big;
    logic [FAR_BITS-1:0]   w10;
    logic                  near_zone;
    logic                  mid_buzz;
    logic                  wrap;
    result_t               res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign stamp_t   = TIME_BITS'(s_tdata);
    assign scale     = (cpc_reg == '0) ? SCALE_BITS'(1) : cpc_reg;

    erhp_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stamp_t - rise_reg),
        .divisor  (scale),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && !s_tuser)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result from the quotient: thresholds on whole centimetres
    always_comb
    begin
        whole     = quotient[DW-1:FRAC_BITS];
        whole_big = |whole[TIME_BITS-1:FAR_BITS];
        w10       = whole[FAR_BITS-1:0];
        near_zone = (w10 < FAR_BITS'(near_reg))
                    || ((w10 == FAR_BITS'(near_reg)) && div_stat.exact);

        res              = '0;
        res.pulse_cycles = 32'(pulse_reg);
        res.distance_q8  = (|quotient[DW-1:16]) ? 16'hFFFF : quotient[15:0];
        res.in_range     = !whole_big && (w10 < far_reg);

        if (w10 < PERIOD_LO_CM)
            res.pace_period = PERIOD_MIN;
        else if (w10 >= PERIOD_HI_CM)
            res.pace_period = PERIOD_MAX;
        else
            res.pace_period = div10(w10[6:0]);

        mid_buzz = 1'b0;
        for (int i = 0; i < NUM_RES; i++)
        begin
            if (res.pace_period == 4'(i + 2))
                mid_buzz = (res_reg[i] == '0);
        end

        if (!res.in_range)
        begin
            res.pace_period = PERIOD_NONE;
            res.buzz        = 1'b0;
        end
        else if (near_zone)
        begin
            res.pace_period = PERIOD_NEAR;
            res.buzz        = 1'b1;
        end
        else
        begin
            res.buzz = mid_buzz;
        end
    end

    assign wrap = &echo_counter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cpc_reg          <= CPC_RESET;
            near_reg         <= NEAR_RESET;
            far_reg          <= FAR_RESET;
            rise_reg         <= '0;
            echo_counter_reg <= '0;
            m_tvalid_reg     <= 1'b0;
            for (int i = 0; i < NUM_RES; i++)
                res_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CYCLES_PER_CM: cpc_reg  <= cfg_data;
                    CFG_NEAR_LIMIT:    near_reg <= cfg_data[NEAR_BITS-1:0];
                    CFG_FAR_LIMIT:     far_reg  <= cfg_data[FAR_BITS-1:0];
                    default:           ;
                endcase
            end

            if (in_accept && s_tuser)
                rise_reg <= stamp_t;

            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            // counter and its residues move together; a wrap to zero clears the residues
            if (load_out && res.in_range)
            begin
                echo_counter_reg <= echo_counter_reg + 1'b1;
                for (int i = 0; i < NUM_RES; i++)
                begin
                    if (wrap || (res_reg[i] == 4'(i + 1)))
                        res_reg[i] <= '0;
                    else
                        res_reg[i] <= res_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
            pulse_reg <= stamp_t - rise_reg;
        if (load_out)
            out_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside of a division");

    a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_reg.in_range) |-> (out_reg.pace_period == PERIOD_NONE && !out_reg.buzz))
        else $error("out of range item carries a period or buzz");

    a_near_buzzes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.pace_period == PERIOD_NEAR) |-> (out_reg.buzz && out_reg.in_range))
        else $error("near zone item without buzz");

    a_counter_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (echo_counter_reg != $past(echo_counter_reg)) |-> $past(load_out && res.in_range))
        else $error("echo counter moved without an in-range result");

endmodule

@@ dv/echo_ranging_haptic_pacer_unit_tb.sv @@
// testbench for echo_ranging_haptic_pacer_unit: echo edges in, range and buzz results checked
// against a cycle-free predictor; depends on erhp_pkg and the unit's rtl
`timescale 1ns / 100ps

module echo_ranging_haptic_pacer_unit_tb;
    import erhp_pkg::*;

    localparam logic EDGE_FALL     = 1'b0;
    localparam logic EDGE_RISE     = 1'b1;
    localparam int   CM_PER_STEP   = 10;
    localparam int   SETTLE_CYCLES = 60;
    localparam int   HOLD_CYCLES   = 500;
    localparam int   EDGES_PER_SET = 107;
    localparam int   NUM_SETS      = 8;
    localparam int   REPORT_LIMIT  = 10;

    typedef struct packed
    {
        logic        rising;
        logic [31:0] stamp;
    } echo_edge_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [31:0]              s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_BITS-1:0]      m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // predictor state and its copy of the registers
    logic [15:0] scale_cfg = CPC_RESET;
    logic [7:0]  near_cfg  = NEAR_RESET;
    logic [9:0]  far_cfg   = FAR_RESET;
    logic [31:0] lead_stamp = '0;
    logic [31:0] echo_tally = '0;

    echo_edge_t  pending_edges[$];
    result_t     expected_ranges[$];
    logic [31:0] gen_rise = '0;
    int          mismatch_count = 0;

    echo_edge_t  next_edge;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    int          mode_left;
    int          stall_mode;
    int          results_seen;
    result_t     got_range;
    result_t     want_range;

    echo_ranging_haptic_pacer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // width, distance and buzz decision of one falling edge
    function automatic result_t range_echo(input logic [31:0] fall_stamp);
        logic [31:0] pulse;
        logic [63:0] scale;
        logic [63:0] whole;
        logic [63:0] q8;
        logic [63:0] period;
        result_t     r;
        pulse = fall_stamp - lead_stamp;
        scale = (scale_cfg == 16'd0) ? 64'd1 : 64'(scale_cfg);
        whole = 64'(pulse) / scale;
        if (whole > 64'd255)
            q8 = 64'd65535;
        else
            q8 = whole * 64'd256 + ((64'(pulse) % scale) * 64'd256) / scale;
        r = '0;
        r.pulse_cycles = pulse;
        r.distance_q8  = q8[15:0];
        r.pace_period  = PERIOD_NONE;
        // in-range test first, so crossed limits leave only the near zone
        if (64'(pulse) < 64'(far_cfg) * scale)
        begin
            r.in_range = 1'b1;
            if (64'(pulse) <= 64'(near_cfg) * scale)
            begin
                r.pace_period = PERIOD_NEAR;
                r.buzz        = 1'b1;
            end
            else
            begin
                period = 64'(pulse) / (64'(CM_PER_STEP) * scale);
                if (period < 64'(PERIOD_MIN))
                    period = 64'(PERIOD_MIN);
                if (period > 64'(PERIOD_MAX))
                    period = 64'(PERIOD_MAX);
                r.pace_period = period[3:0];
                r.buzz        = (echo_tally % period[31:0]) == 32'd0;
            end
            echo_tally = echo_tally + 32'd1;
        end
        return r;
    endfunction

    // pulse widths clustered on the zone and period boundaries of the current setting
    function automatic logic [31:0] pick_pulse();
        logic [63:0] scale;
        logic [63:0] base_cm;
        logic [63:0] top_cm;
        scale  = (scale_cfg == 16'd0) ? 64'd1 : 64'(scale_cfg);
        top_cm = ((far_cfg > 10'(near_cfg)) ? 64'(far_cfg) : 64'(near_cfg)) + 64'd12;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'($urandom_range(0, 3));
            2, 3:
            begin
                case ($urandom_range(0, 5))
                    0: base_cm = 64'(near_cfg);
                    1: base_cm = 64'(far_cfg);
                    2: base_cm = 64'(PERIOD_LO_CM);
                    3: base_cm = 64'd30;
                    4: base_cm = 64'(PERIOD_HI_CM);
                    default: base_cm = 64'd110;
                endcase
                return 32'(base_cm * scale) + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default:
            begin
                base_cm = 64'($urandom_range(0, 32'(top_cm)));
                return 32'(base_cm * scale + 64'($urandom_range(0, 32'(scale - 64'd1))));
            end
        endcase
    endfunction

    task automatic push_edge(input logic rising, input logic [31:0] stamp);
        echo_edge_t e;
        e.rising = rising;
        e.stamp  = stamp;
        if (rising == EDGE_RISE)
            gen_rise = stamp;
        pending_edges.push_back(e);
    endtask

    task automatic push_random_edges(input int count);
        int n;
        int falls;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 19))
                // lone fall measured from whatever rise came last
                0:
                begin
                    push_edge(EDGE_FALL, gen_rise + pick_pulse());
                    n = n + 1;
                end
                // a rise that a second rise overwrites
                1:
                begin
                    push_edge(EDGE_RISE, $urandom);
                    push_edge(EDGE_RISE, $urandom);
                    push_edge(EDGE_FALL, gen_rise + pick_pulse());
                    n = n + 3;
                end
                // several falls sharing one rise
                2:
                begin
                    push_edge(EDGE_RISE, $urandom);
                    falls = $urandom_range(2, 4);
                    repeat (falls)
                        push_edge(EDGE_FALL, gen_rise + pick_pulse());
                    n = n + 1 + falls;
                end
                default:
                begin
                    push_edge(EDGE_RISE, $urandom);
                    push_edge(EDGE_FALL, gen_rise + pick_pulse());
                    n = n + 2;
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CYCLES_PER_CM: scale_cfg = value;
            CFG_NEAR_LIMIT:    near_cfg  = value[7:0];
            CFG_FAR_LIMIT:     far_cfg   = value[9:0];
            default: ;
        endcase
    endtask

    task automatic write_setting(input logic [15:0] cpc, input logic [7:0] near_cm,
                                 input logic [9:0] far_cm);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_CYCLES_PER_CM, cpc);
        // unused upper bits carry noise
        write_reg(CFG_NEAR_LIMIT, {junk[15:8], near_cm});
        write_reg(CFG_FAR_LIMIT, {junk[5:0], far_cm});
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_edges.size() != 0 || s_tvalid || expected_ranges.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %0d: %s expected 0x%0h got 0x%0h", mismatch_count, what,
                     want, got);
    endtask

    // sender: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= EDGE_FALL;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == EDGE_RISE)
                    lead_stamp = s_tdata;
                else
                    expected_ranges.push_back(range_echo(s_tdata));
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_edges.size() != 0)
                begin
                    next_edge = pending_edges.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_edge.rising;
                    s_tdata  <= next_edge.stamp;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall modes that change every so often, plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_mode   <= 0;
            mode_left    <= 0;
            hold_left    <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                results_seen <= results_seen + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (m_tvalid && m_tready && (results_seen == 150 || results_seen == 450))
            begin
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left  <= $urandom_range(16, 200);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (mode_left[1:0] == 2'd0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_range = m_tdata;
            if (expected_ranges.size() == 0)
                flag_mismatch("result with nothing pending, tdata", '0, 64'(m_tdata));
            else
            begin
                want_range = expected_ranges.pop_front();
                if (got_range.pulse_cycles !== want_range.pulse_cycles)
                    flag_mismatch("pulse_cycles", 64'(want_range.pulse_cycles),
                                  64'(got_range.pulse_cycles));
                if (got_range.distance_q8 !== want_range.distance_q8)
                    flag_mismatch("distance_q8", 64'(want_range.distance_q8),
                                  64'(got_range.distance_q8));
                if (got_range.in_range !== want_range.in_range)
                    flag_mismatch("in_range", 64'(want_range.in_range),
                                  64'(got_range.in_range));
                if (got_range.pace_period !== want_range.pace_period)
                    flag_mismatch("pace_period", 64'(want_range.pace_period),
                                  64'(got_range.pace_period));
                if (got_range.buzz !== want_range.buzz)
                    flag_mismatch("buzz", 64'(want_range.buzz), 64'(got_range.buzz));
                if (got_range.pad !== want_range.pad)
                    flag_mismatch("tdata fill bits", 64'(want_range.pad), 64'(got_range.pad));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [15:0] cpc;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting: scale 9280, near 20, far 150
        push_edge(EDGE_FALL, 32'd0);                    // fall before any rise
        push_edge(EDGE_FALL, 32'd185600);               // exactly at near limit
        push_edge(EDGE_FALL, 32'd185601);               // just past near limit
        push_edge(EDGE_FALL, 32'd1391999);              // last cycle in range
        push_edge(EDGE_FALL, 32'd1392000);              // first cycle out of range
        push_edge(EDGE_FALL, 32'hFFFF_FFFF);            // saturated distance
        push_edge(EDGE_RISE, 32'hFFFF_FF00);
        push_edge(EDGE_FALL, 32'h0000_0100);            // stamp wraps between edges
        push_edge(EDGE_RISE, 32'd1000);
        push_edge(EDGE_RISE, 32'd5000);                 // second rise wins
        push_edge(EDGE_FALL, 32'd5000 + 32'd510400);    // 55 cm
        push_edge(EDGE_FALL, 32'd5000 + 32'd918725);    // just over 99 cm
        push_edge(EDGE_FALL, 32'd5000 + 32'd278400);    // exactly 30 cm
        push_edge(EDGE_FALL, 32'd5000 + 32'd974400);    // 105 cm, period capped
        push_edge(EDGE_RISE, 32'hFFFF_FFFF);
        push_edge(EDGE_FALL, 32'hFFFF_FFFF);            // zero width
        push_edge(EDGE_RISE, 32'd0);
        push_edge(EDGE_FALL, 32'd928000);               // exactly 100 cm
        push_edge(EDGE_FALL, 32'd232000);               // 25 cm
        push_edge(EDGE_FALL, 32'd232000);
        wait_idle();

        for (int set = 0; set < NUM_SETS; set++)
        begin
            case (set)
                0: write_setting(16'd0, 8'd5, 10'd40);          // zero scale acts as one
                1: write_setting(16'hFFFF, 8'hFF, 10'h3FF);
                2: write_setting(16'd1, 8'd0, 10'd0);           // nothing in range
                3: write_setting(16'd120, 8'd200, 10'd60);      // crossed limits
                4: write_setting(16'd58, 8'd20, 10'd150);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: cpc = 16'($urandom_range(1, 64));
                        1: cpc = 16'($urandom_range(65, 2000));
                        2: cpc = 16'($urandom);
                        default: cpc = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
                    endcase
                    write_setting(cpc, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
                end
            endcase
            @(negedge clk);
            push_random_edges(EDGES_PER_SET);
            wait_idle();
        end

        if (mismatch_count == 0 && expected_ranges.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/erhp_pkg.sv
hw/rtl/erhp_div.sv
hw/rtl/echo_ranging_haptic_pacer_unit.sv
dv/echo_ranging_haptic_pacer_unit_tb.sv
